[sv/stq_pkg.sv]
// Shared constants and codes for the symmetric tensor quantizer.
package stq_pkg;

    localparam int unsigned SAMPLE_FRAC = 8;   // fraction bits of a sample
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SCALE_W     = 29;
    localparam int unsigned M_TDATA_W   = 40;  // byte + scale, padded to whole bytes
    localparam int unsigned QMAX_W      = 7;
    localparam int unsigned Q_STEPS     = 7;   // quotient bits below the clamp point

    localparam logic [QMAX_W-1:0] QMAX_INT8 = 7'd127;
    localparam logic [QMAX_W-1:0] QMAX_INT4 = 7'd7;
    localparam logic [3:0]        NIB_BIAS  = 4'd8;

    localparam logic MODE_INT8 = 1'b0;
    localparam logic MODE_INT4 = 1'b1;

    localparam logic FUNC_MEASURE  = 1'b0;
    localparam logic FUNC_QUANTISE = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_SCALE = 1'b1;

endpackage

[sv/stq_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module stq_div #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DSH_W = 39,
    parameter int unsigned QUO_W = 30,
    parameter int unsigned CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DSH_W-1:0] dsh,    // divisor already shifted to the top quotient bit
    input  logic [CNT_W-1:0] steps,  // index of the top quotient bit
    output logic             done,   // final step this cycle, quotient valid next cycle
    output logic [QUO_W-1:0] quo
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] rem_next;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ge;

    always_comb begin
        ge       = DSH_W'(rem_reg) >= dsh_reg;
        rem_next = ge ? (rem_reg - NUM_W'(dsh_reg)) : rem_reg;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= steps;
            rem_reg <= num;
            dsh_reg <= dsh;
            quo_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

endmodule

[sv/symmetric_tensor_quantizer.sv]
// Top level of the two-pass symmetric int8 / packed int4 tensor quantizer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  s_       | s_tvalid / s_tready     | tdata: sample; tuser: func; tlast: last
//  m_       | m_tvalid / m_tready     | tdata: byte_value, scale_value; tuser: kind;
//           |                         | tlast: end_of_tensor
//  cfg      | cfg_wen                 | cfg_wdata: mode
//
// One beat at a time. A quantise beat is accepted, runs Q_STEPS+1 divider steps, then
// forms its result; after a zero peak it runs SAMPLE_WIDTH-7 steps of the unit divide.
// A closing measure beat runs the scale divide, or skips it on a zero peak.
// Only open measure beats return straight to idle; a held nibble still runs the divider.
// A finished result sits in the output register; the next beat is taken meanwhile,
// but a further result waits until m_tready empties it. Reset is synchronous.
module symmetric_tensor_quantizer
    import stq_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH        = 16,
    parameter int unsigned SCALE_FRACTION_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic                                   cfg_wdata,  // mode
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,    // sample
    input  logic                                   s_tlast,    // last
    input  logic                                   s_tuser,    // func
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [M_TDATA_W-1:0]                   m_tdata,    // byte_value, scale_value
    output logic                                   m_tlast,    // end_of_tensor
    output logic                                   m_tuser     // kind
);

    localparam int unsigned NUM_W = SAMPLE_WIDTH +
                                    ((SCALE_FRACTION_BITS > 9) ? SCALE_FRACTION_BITS : 9);
    localparam int unsigned DSH_W = NUM_W + 7;
    localparam int unsigned QUO_W = SAMPLE_WIDTH + SCALE_FRACTION_BITS - 2;
    localparam int unsigned CNT_W = $clog2(QUO_W);
    localparam int unsigned MQ_W  = SAMPLE_WIDTH + 7;
    localparam int unsigned STEPS_SCALE = QUO_W - 1;
    localparam int unsigned STEPS_UNIT  = SAMPLE_WIDTH - 8;
    localparam logic [SCALE_W-1:0] SCALE_ONE =
        ((SAMPLE_FRAC + SCALE_FRACTION_BITS) < SCALE_W) ?
        (SCALE_W'(1) << (SAMPLE_FRAC + SCALE_FRACTION_BITS)) : '0;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

    state_t                  state_reg, state_next;
    logic                    mode_reg, mode_next;
    logic [SAMPLE_WIDTH-1:0] peak_reg, peak_next;
    logic                    open_reg, open_next;
    logic                    odd_reg, odd_next;
    logic [3:0]              held_reg, held_next;
    logic                    job_scale_reg, job_scale_next;
    logic                    job_one_reg, job_one_next;
    logic                    job_neg_reg, job_neg_next;
    logic                    job_last_reg, job_last_next;
    logic                    job_ovf_reg, job_ovf_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic                    m_tuser_reg, m_tuser_next;

    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    neg;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SAMPLE_WIDTH-1:0] peak_meas;
    logic [QMAX_W-1:0]       qmax;
    logic [MQ_W-1:0]         mag_x_q;
    logic [NUM_W-1:0]        num_quant, num_scale, num_unit;
    logic [DSH_W-1:0]        dsh_quant, dsh_scale, dsh_unit;
    logic                    ovf;

    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DSH_W-1:0]        div_dsh;
    logic [CNT_W-1:0]        div_steps;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;

    logic                    sat;
    logic [QMAX_W-1:0]       q7;
    logic [BYTE_W-1:0]       code;
    logic [3:0]              nib;
    logic                    has_res;
    logic [BYTE_W-1:0]       res_byte;
    logic [SCALE_W-1:0]      res_scale;
    logic                    out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // operand preparation for the three kinds of division
    always_comb begin
        sample    = s_tdata[SAMPLE_WIDTH-1:0];
        neg       = sample[SAMPLE_WIDTH-1];
        mag       = neg ? (~sample + SAMPLE_WIDTH'(1)) : sample;
        peak_meas = (!open_reg || (mag > peak_reg)) ? mag : peak_reg;
        qmax      = (mode_reg == MODE_INT4) ? QMAX_INT4 : QMAX_INT8;
        mag_x_q   = (mode_reg == MODE_INT4) ?
                    (MQ_W'({mag, 3'b000}) - MQ_W'(mag)) :
                    (MQ_W'({mag, 7'b0000000}) - MQ_W'(mag));
        // round half away: (2*mag*qmax + peak) / (2*peak)
        num_quant = NUM_W'({mag_x_q, 1'b0}) + NUM_W'(peak_reg);
        dsh_quant = DSH_W'({peak_reg, 1'b0}) << Q_STEPS;
        ovf       = DSH_W'(num_quant) >= dsh_quant;
        num_scale = (NUM_W'(peak_meas) << SCALE_FRACTION_BITS) + NUM_W'(qmax >> 1);
        dsh_scale = DSH_W'(qmax) << STEPS_SCALE;
        // zero peak: round(mag / 256) as a division by 256
        num_unit  = NUM_W'(mag) + (NUM_W'(1) << (SAMPLE_FRAC - 1));
        dsh_unit  = DSH_W'(1) << SAMPLE_WIDTH;
    end

    // result formation from the quotient
    always_comb begin
        sat       = job_ovf_reg || (div_quo > QUO_W'(qmax));
        q7        = sat ? qmax : div_quo[QMAX_W-1:0];
        code      = job_neg_reg ? (BYTE_W'(0) - BYTE_W'(q7)) : BYTE_W'(q7);
        nib       = job_neg_reg ? (NIB_BIAS - q7[3:0]) : (NIB_BIAS + q7[3:0]);
        res_scale = job_scale_reg ? (job_one_reg ? SCALE_ONE : SCALE_W'(div_quo)) : '0;
        if (job_scale_reg) begin
            has_res  = 1'b1;
            res_byte = '0;
        end else if (mode_reg == MODE_INT8) begin
            has_res  = 1'b1;
            res_byte = code;
        end else begin
            has_res  = odd_reg || job_last_reg;
            res_byte = odd_reg ? {nib, held_reg} : {4'b0000, nib};
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = cfg_wen ? cfg_wdata : mode_reg;
        peak_next      = peak_reg;
        open_next      = open_reg;
        odd_next       = odd_reg;
        held_next      = held_reg;
        job_scale_next = job_scale_reg;
        job_one_next   = job_one_reg;
        job_neg_next   = job_neg_reg;
        job_last_next  = job_last_reg;
        job_ovf_next   = job_ovf_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;
        div_start      = 1'b0;
        div_num        = num_quant;
        div_dsh        = dsh_quant;
        div_steps      = CNT_W'(Q_STEPS);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    open_next     = !s_tlast;
                    job_last_next = s_tlast;
                    if (s_tuser == FUNC_MEASURE) begin
                        peak_next = peak_meas;
                        if (s_tlast) begin
                            job_scale_next = 1'b1;
                            job_neg_next   = 1'b0;
                            job_ovf_next   = 1'b0;
                            if (peak_meas == '0) begin
                                job_one_next = 1'b1;
                                state_next   = ST_FIN;
                            end else begin
                                job_one_next = 1'b0;
                                div_start    = 1'b1;
                                div_num      = num_scale;
                                div_dsh      = dsh_scale;
                                div_steps    = CNT_W'(STEPS_SCALE);
                                state_next   = ST_DIV;
                            end
                        end
                    end else begin
                        if (!open_reg) begin
                            odd_next  = 1'b0;
                            held_next = '0;
                        end
                        job_scale_next = 1'b0;
                        job_one_next   = 1'b0;
                        job_neg_next   = neg;
                        div_start      = 1'b1;
                        state_next     = ST_DIV;
                        if (peak_reg == '0) begin
                            job_ovf_next = 1'b0;
                            div_num      = num_unit;
                            div_dsh      = dsh_unit;
                            div_steps    = CNT_W'(STEPS_UNIT);
                        end else begin
                            job_ovf_next = ovf;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!has_res || out_free) begin
                    state_next = ST_IDLE;
                    if (!job_scale_reg) begin
                        if (mode_reg == MODE_INT4 && !odd_reg && !job_last_reg) begin
                            held_next = nib;
                            odd_next  = 1'b1;
                        end else begin
                            held_next = '0;
                            odd_next  = 1'b0;
                        end
                    end
                    if (has_res) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = M_TDATA_W'({res_scale, res_byte});
                        m_tlast_next  = job_last_reg;
                        m_tuser_next  = job_scale_reg ? KIND_SCALE : KIND_BYTE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_INT8;
            peak_reg     <= '0;
            open_reg     <= 1'b0;
            odd_reg      <= 1'b0;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            peak_reg      <= peak_next;
            open_reg      <= open_next;
            odd_reg       <= odd_next;
            held_reg      <= held_next;
            job_scale_reg <= job_scale_next;
            job_one_reg   <= job_one_next;
            job_neg_reg   <= job_neg_next;
            job_last_reg  <= job_last_next;
            job_ovf_reg   <= job_ovf_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tlast_reg   <= m_tlast_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    stq_div #(
        .NUM_W (NUM_W),
        .DSH_W (DSH_W),
        .QUO_W (QUO_W),
        .CNT_W (CNT_W)
    ) u_stq_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .dsh     (div_dsh),
        .steps   (div_steps),
        .done    (div_done),
        .quo     (div_quo)
    );

endmodule

[sv/stq_checker.sv]
// Port-level checks for the tensor quantizer, bound to the top level.
module stq_checker
    import stq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // scale beats carry no byte and always close the pass
    a_scale_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SCALE) |->
            (m_tdata[BYTE_W-1:0] == '0) && m_tlast
            && (m_tdata[M_TDATA_W-1:BYTE_W+SCALE_W] == '0))
        else $error("malformed scale beat");

    // byte beats carry no scale
    a_byte_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_BYTE) |->
            (m_tdata[M_TDATA_W-1:BYTE_W] == '0))
        else $error("malformed byte beat");

    // closing a measure pass leaves idle for the divider or the result, so the next cycle takes no input
    a_scale_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_MEASURE) && s_tlast |=> !s_tready)
        else $error("input taken while scale is being computed");

endmodule

bind symmetric_tensor_quantizer stq_checker u_stq_checker (.*);

[tb/sv/quantizer_result_monitor.sv]
// Stream monitor for the tensor quantizer: tracks mode, predicts results, compares output beats.
module quantizer_result_monitor
    import stq_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH        = 16,
    parameter int unsigned SCALE_FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic                                cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,    // sample
    input  logic                                s_tlast,    // last
    input  logic                                s_tuser,    // func
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [M_TDATA_W-1:0]                m_tdata,    // byte_value, scale_value
    input  logic                                m_tlast,    // end_of_tensor
    input  logic                                m_tuser,    // kind
    output int                                  failures,
    output int                                  results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [SCALE_W-1:0] scale_value;
        logic               eot;
    } quant_result_t;

    quant_result_t   awaited_results[$];
    logic            mode         = MODE_INT8;
    longint unsigned peak         = 0;
    bit              pass_open    = 1'b0;
    bit              odd_slot     = 1'b0;
    logic [3:0]      held_nibble  = '0;
    int              mismatches   = 0;

    // Returns 1 when the beat yields a result; updates the quantizer state.
    function automatic bit quantise_beat(input logic func, input logic [SAMPLE_WIDTH-1:0] sample,
                                         input logic last, output quant_result_t res);
        bit              neg;
        longint unsigned mag;
        longint unsigned qmax;
        longint unsigned q;
        logic [3:0]      nib;
        neg  = sample[SAMPLE_WIDTH-1];
        mag  = neg ? ((64'd1 << SAMPLE_WIDTH) - 64'(sample)) : 64'(sample);
        qmax = (mode == MODE_INT4) ? 64'(QMAX_INT4) : 64'(QMAX_INT8);
        res  = '0;

        if (func == FUNC_MEASURE) begin
            if (!pass_open || mag > peak)
                peak = mag;
            if (!last) begin
                pass_open = 1'b1;
                return 1'b0;
            end
            pass_open = 1'b0;
            res.kind  = KIND_SCALE;
            res.eot   = 1'b1;
            if (peak == 0)
                res.scale_value = SCALE_W'(64'd1 << (SAMPLE_FRAC + SCALE_FRACTION_BITS));
            else
                res.scale_value = SCALE_W'(((peak << SCALE_FRACTION_BITS) + qmax / 2) / qmax);
            return 1'b1;
        end

        if (!pass_open) begin
            odd_slot    = 1'b0;
            held_nibble = '0;
        end
        pass_open = !last;

        // zero peak: treat as unit scale, round half away on the fraction
        if (peak == 0)
            q = (mag + (64'd1 << (SAMPLE_FRAC - 1))) >> SAMPLE_FRAC;
        else
            q = (2 * mag * qmax + peak) / (2 * peak);
        if (q > qmax)
            q = qmax;
        res.kind = KIND_BYTE;

        if (mode == MODE_INT8) begin
            odd_slot        = 1'b0;
            held_nibble     = '0;
            res.byte_value  = neg ? BYTE_W'(0 - q) : BYTE_W'(q);
            res.eot         = last;
            return 1'b1;
        end

        nib = neg ? 4'(64'(NIB_BIAS) - q) : 4'(64'(NIB_BIAS) + q);
        if (!odd_slot) begin
            if (last) begin
                held_nibble    = '0;
                res.byte_value = {4'h0, nib};
                res.eot        = 1'b1;
                return 1'b1;
            end
            held_nibble = nib;
            odd_slot    = 1'b1;
            return 1'b0;
        end
        res.byte_value = {nib, held_nibble};
        res.eot        = last;
        odd_slot       = 1'b0;
        held_nibble    = '0;
        return 1'b1;
    endfunction

    task automatic note_failure(input string why, input quant_result_t want,
                                input quant_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t: %s: expected kind %0d byte 0x%02h scale 0x%08h eot %0d, ",
                   $realtime, why, want.kind, want.byte_value, want.scale_value, want.eot);
            $display("got kind %0d byte 0x%02h scale 0x%08h eot %0d",
                     got.kind, got.byte_value, got.scale_value, got.eot);
        end
    endtask

    always @(posedge aclk) begin : watch
        quant_result_t got;
        quant_result_t want;
        quant_result_t fresh;
        if (!aresetn) begin
            awaited_results.delete();
            mode        = MODE_INT8;
            peak        = 0;
            pass_open   = 1'b0;
            odd_slot    = 1'b0;
            held_nibble = '0;
        end else begin
            // output beat first: a result never leaves on the edge its input is taken
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[BYTE_W-1:0], m_tdata[BYTE_W+SCALE_W-1:BYTE_W], m_tlast};
                if (awaited_results.size() == 0) begin
                    note_failure("unexpected result beat", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                        note_failure("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                if (quantise_beat(s_tuser, s_tdata[SAMPLE_WIDTH-1:0], s_tlast, fresh))
                    awaited_results.push_back(fresh);
            end
            if (cfg_wen)
                mode = cfg_wdata;
        end
        results_pending <= awaited_results.size();
        failures        <= mismatches;
    end

endmodule

[tb/sv/symmetric_tensor_quantizer_test.sv]
// Stimulus and verdict for the symmetric tensor quantizer: directed passes, random tensors.
module symmetric_tensor_quantizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned SCALE_FRAC    = 16;
    localparam int unsigned S_TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_BEATS  = 580;
    localparam int unsigned MAX_TENSOR    = 24;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wen;
    logic                   cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    int                     failures;
    int                     results_pending;
    int                     beats_sent    = 0;
    int                     hold_requests = 0;
    int                     holds_done    = 0;
    bit                     calm          = 1'b0;
    logic [SAMPLE_W-1:0]    tensor [0:MAX_TENSOR-1];

    symmetric_tensor_quantizer #(
        .SAMPLE_WIDTH        (SAMPLE_W),
        .SCALE_FRACTION_BITS (SCALE_FRAC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    quantizer_result_monitor #(
        .SAMPLE_WIDTH        (SAMPLE_W),
        .SCALE_FRACTION_BITS (SCALE_FRAC)
    ) monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .failures        (failures),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("symmetric_tensor_quantizer test failed");
        $finish;
    end

    // Result side: random back-pressure, or a long hold when one is requested.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_beat(input logic func, input logic [SAMPLE_W-1:0] sample,
                             input logic last);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= sample;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // Stop offering, let every awaited result arrive, then allow for silent beats.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned amp);
        unique case ($urandom_range(9))
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2:       return SAMPLE_W'($urandom);
            default: return SAMPLE_W'(int'($urandom_range(2 * amp)) - int'(amp));
        endcase
    endfunction

    // One tensor: measure then quantise the same samples, with a few odd variants.
    task automatic run_tensor();
        int unsigned n;
        int unsigned amp;
        int unsigned style;
        n     = ($urandom_range(7) == 0) ? MAX_TENSOR : $urandom_range(1, 12);
        amp   = ($urandom_range(3) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 32767);
        style = $urandom_range(9);
        for (int i = 0; i < n; i++)
            tensor[i] = (style == 0) ? '0 : pick_sample(amp);
        if (style == 9) begin
            // noise: mixed funcs and stray last flags
            for (int i = 0; i < n; i++)
                send_beat(logic'($urandom_range(1)), SAMPLE_W'($urandom),
                          $urandom_range(3) == 0);
        end else begin
            for (int i = 0; i < n; i++)
                send_beat(FUNC_MEASURE, tensor[i], i == n - 1);
            // zero tensor gets small values; style 8 quantises unmeasured data to hit the clamp
            if (style == 0 || style == 8)
                for (int i = 0; i < n; i++)
                    tensor[i] = pick_sample(style == 0 ? 400 : 32767);
            for (int i = 0; i < n; i++)
                send_beat(FUNC_QUANTISE, tensor[i], i == n - 1);
        end
    endtask

    initial begin
        int directed_beats;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= MODE_INT8;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= FUNC_MEASURE;
        repeat (6) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // int8, full-scale peak from the most negative sample
        send_beat(FUNC_MEASURE, 16'h7FFF, 1'b0);
        send_beat(FUNC_MEASURE, 16'h8000, 1'b0);
        send_beat(FUNC_MEASURE, 16'h0000, 1'b0);
        send_beat(FUNC_MEASURE, 16'h0001, 1'b1);
        send_beat(FUNC_QUANTISE, 16'h8000, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h7FFF, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h0000, 1'b0);
        send_beat(FUNC_QUANTISE, 16'hFFFF, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h0080, 1'b1);
        // zero peak: unit scale, halves round away, large values clamp
        send_beat(FUNC_MEASURE, 16'h0000, 1'b1);
        send_beat(FUNC_QUANTISE, 16'h0080, 1'b0);
        send_beat(FUNC_QUANTISE, 16'hFF80, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h7FFF, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h8000, 1'b1);

        set_mode(MODE_INT4);
        send_beat(FUNC_MEASURE, 16'h03E8, 1'b0);
        send_beat(FUNC_MEASURE, 16'hFC18, 1'b0);
        send_beat(FUNC_MEASURE, 16'h0100, 1'b1);
        // odd count: last nibble goes out alone
        send_beat(FUNC_QUANTISE, 16'h03E8, 1'b0);
        send_beat(FUNC_QUANTISE, 16'hFC18, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h0001, 1'b1);
        send_beat(FUNC_QUANTISE, 16'h0200, 1'b1);
        // measure beat inside an open quantise pass raises the peak
        send_beat(FUNC_QUANTISE, 16'h0100, 1'b0);
        send_beat(FUNC_MEASURE, 16'h7000, 1'b0);
        send_beat(FUNC_QUANTISE, 16'h0100, 1'b1);
        // nibble held, then int8 beat drops it
        send_beat(FUNC_QUANTISE, 16'h0064, 1'b0);
        set_mode(MODE_INT8);
        send_beat(FUNC_QUANTISE, 16'h0064, 1'b1);
        directed_beats = beats_sent;

        for (int phase = 0; beats_sent < directed_beats + RANDOM_BEATS; phase++) begin
            set_mode(logic'($urandom_range(1)));
            calm = (phase == 2);
            if (phase == 1)
                hold_requests++;
            repeat ((phase == 2) ? 8 : $urandom_range(2, 5)) run_tensor();
        end
        calm = 1'b0;

        drain();
        if (failures == 0 && results_pending == 0)
            $display("symmetric_tensor_quantizer test passed");
        else
            $display("symmetric_tensor_quantizer test failed");
        $finish;
    end

endmodule
